// ===== hdl/wmtm_pkg.sv =====
// Shared types and constants of the window median / trimmed mean filter.
`default_nettype none

package wmtm_pkg;

    localparam int PIXEL_W = 8;

    typedef struct packed {
        logic               insert;
        logic               scan;
        logic               clear;
        logic [PIXEL_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/window_median_trimmed_mean_top.sv =====
// Top level of the window median / trimmed mean filter with its sorting chain.
//
//  Channel   Signals                                  Direction  Transaction when
//  pixel     pixel_valid pixel_stall pixel_value      in         valid high, stall low
//            last_in_window
//  result    result_valid result_stall filtered_value out        valid high, stall low
//  cfg       cfg_valid cfg_ready neighbor_span        in         valid and ready high
//
// While a window loads, one pixel is taken per cycle and inserted into the sorting chain.
// At a window end the chain is scanned up to hi, the highest averaged sorted index,
// then the sum is divided (load, one step per bit of the sum, finish),
// then the result is handed over to the output register.
// Reset empties the chain at once through the cell occupancy flags; there is no clear pass.
// A finished result waits with pixel_stall high while the output register still holds
// a result that has not been taken.
`default_nettype none

module window_median_trimmed_mean_top
    import wmtm_pkg::*;
#(
    parameter int MAX_WINDOW = 81
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pixel_valid,
    output logic                    pixel_stall,
    input  wire logic [PIXEL_W-1:0] pixel_value,
    input  wire logic               last_in_window,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic      [PIXEL_W-1:0] filtered_value,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         neighbor_span
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SPAN_W = 6;
    localparam int K_W    = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;
    localparam int SUM_W  = $clog2(MAX_WINDOW * 255 + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SPAN_W-1:0]  span_reg;
    logic [SPAN_W-1:0]  span_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIXEL_W-1:0] out_value_reg;
    logic [PIXEL_W-1:0] out_value_next;
    logic               div_start_reg;
    logic               div_start_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   lo_next;
    logic [CNT_W-1:0]   hi_reg;
    logic [CNT_W-1:0]   hi_next;
    logic [CNT_W-1:0]   den_reg;
    logic [CNT_W-1:0]   den_next;
    logic [SUM_W-1:0]   acc_reg;
    logic [SUM_W-1:0]   acc_next;

    logic               pixel_take;
    logic               full;
    logic [CNT_W-1:0]   n_total;
    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   lim;
    logic [K_W-1:0]     span_ext;
    logic [K_W-1:0]     lim_ext;
    logic [CNT_W-1:0]   k_sat;
    logic               div_done;
    logic [PIXEL_W-1:0] div_quotient;
    cell_ctrl_t         cell_ctrl;

    logic [PIXEL_W-1:0] cell_value [MAX_WINDOW];
    logic               cell_cond  [MAX_WINDOW];
    logic               cell_valid [MAX_WINDOW];

    assign pixel_stall    = (state_reg != ST_LOAD);
    assign pixel_take     = pixel_valid && !pixel_stall;
    assign cfg_ready      = 1'b1;
    assign result_valid   = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign full           = cell_valid[MAX_WINDOW-1];

    assign cell_ctrl.insert = pixel_take && !full;
    assign cell_ctrl.scan   = (state_reg == ST_SCAN);
    assign cell_ctrl.clear  = pixel_take && last_in_window;
    assign cell_ctrl.value  = pixel_value;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            logic [PIXEL_W-1:0] left_value;
            logic               left_cond;
            logic               left_valid;
            logic [PIXEL_W-1:0] right_value;

            if (gi == 0)
            begin : g_head
                assign left_value = pixel_value;
                assign left_cond  = 1'b0;
                assign left_valid = 1'b1;
            end
            else
            begin : g_body
                assign left_value = cell_value[gi-1];
                assign left_cond  = cell_cond[gi-1];
                assign left_valid = cell_valid[gi-1];
            end

            if (gi == MAX_WINDOW - 1)
            begin : g_tail
                assign right_value = '0;
            end
            else
            begin : g_inner
                assign right_value = cell_value[gi+1];
            end

            wmtm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .left_value  (left_value),
                .left_cond   (left_cond),
                .left_valid  (left_valid),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .cond        (cell_cond[gi]),
                .valid       (cell_valid[gi])
            );
        end
    endgenerate

    wmtm_div #(
        .SUM_W (SUM_W),
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (acc_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Window geometry, taken with the closing pixel already counted.
    assign n_total  = full ? count_reg : count_reg + 1'b1;
    assign mid      = n_total >> 1;
    assign lim      = (n_total - 1'b1) >> 1;
    assign span_ext = K_W'(span_reg);
    assign lim_ext  = K_W'(lim);
    assign k_sat    = (span_ext > lim_ext) ? lim : CNT_W'(span_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        span_next      = span_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        div_start_next = 1'b0;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        den_next       = den_reg;
        acc_next       = acc_reg;

        if (cfg_valid && cfg_ready)
        begin
            span_next = neighbor_span;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (pixel_take)
                begin
                    if (last_in_window)
                    begin
                        count_next = '0;
                        lo_next    = mid - k_sat;
                        hi_next    = mid + k_sat;
                        den_next   = CNT_W'({k_sat, 1'b1});
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (!full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg >= lo_reg)
                begin
                    acc_next = acc_reg + SUM_W'(cell_value[0]);
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == hi_reg)
                begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = div_quotient;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            span_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            span_reg      <= span_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            div_start_reg <= div_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        den_reg <= den_next;
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

// ===== hdl/wmtm_cell.sv =====
// One cell of the sorting chain: holds one window value and its occupancy flag.
`default_nettype none

module wmtm_cell
    import wmtm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [PIXEL_W-1:0] left_value,
    input  wire logic               left_cond,
    input  wire logic               left_valid,
    input  wire logic [PIXEL_W-1:0] right_value,
    output logic      [PIXEL_W-1:0] value,
    output logic                    cond,
    output logic                    valid
);

    logic [PIXEL_W-1:0] value_reg;
    logic [PIXEL_W-1:0] value_next;
    logic               valid_reg;
    logic               valid_next;

    // A cell yields its place to the new value when it is empty or holds a larger value.
    assign cond  = !valid_reg || (value_reg > ctrl.value);
    assign value = value_reg;
    assign valid = valid_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            valid_next = left_valid;
            if (left_cond)
            begin
                value_next = left_value;
            end
            else if (cond)
            begin
                value_next = ctrl.value;
            end
        end
        else if (ctrl.scan)
        begin
            value_next = right_value;
        end
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ===== hdl/wmtm_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module wmtm_div
    import wmtm_pkg::*;
#(
    parameter int SUM_W = 15,
    parameter int DIV_W = 7
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [SUM_W-1:0]   dividend,
    input  wire logic [DIV_W-1:0]   divisor,
    output logic                    done,
    output logic      [PIXEL_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic [SUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] quo_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W-1:0] den_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [DIV_W:0]   partial;
    logic [DIV_W+1:0] diff;
    logic             borrow;

    assign partial  = {rem_reg, quo_reg[SUM_W-1]};
    assign diff     = {1'b0, partial} - {2'b00, den_reg};
    assign borrow   = diff[DIV_W+1];
    assign done     = done_reg;
    assign quotient = quo_reg[PIXEL_W-1:0];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], !borrow};
            rem_next = borrow ? partial[DIV_W-1:0] : diff[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

`default_nettype wire
